/* src/vbmm_pkg.sv */
// Package for the brick min/max block: types, constants, state encoding.
// No dependencies.
`default_nettype none
package vbmm_pkg;
  localparam int MAX_BRICKS  = 4096;
  localparam int BRICK_BITS  = $clog2(MAX_BRICKS);
  localparam int DIV_BITS    = 30;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OUTSIDE  = 2'd1;
  localparam logic [1:0] ST_BEYOND   = 2'd2;

  localparam logic [1:0] REG_DIM_X  = 2'd0;
  localparam logic [1:0] REG_DIM_Y  = 2'd1;
  localparam logic [1:0] REG_DIM_Z  = 2'd2;
  localparam logic [1:0] REG_BRICK  = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [29:0]       voxel_index;
    logic signed [31:0] sample_value;
    logic [11:0]       read_brick;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [11:0]        brick_number;
    logic signed [31:0] brick_min;
    logic signed [31:0] brick_max;
    logic               brick_seen;
  } out_item_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_VOLCHK, OP_DIV_X, OP_DIV_Y, OP_DIV_BX, OP_DIV_BY,
    OP_DIV_BZ, OP_DIV_NX, OP_DIV_NY, OP_SUM, OP_RD, OP_WR, OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic div_start;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic is_read;
    logic outside;
    logic clearing;
  } sts_t;

  typedef enum logic [3:0] {
    S_IDLE, S_VOL, S_DX, S_DY, S_BX, S_BY, S_BZ, S_NX, S_NY, S_SUM,
    S_RD, S_WR, S_OUT
  } state_t;
endpackage
`default_nettype wire

/* src/vbmm_div.sv */
// Restoring divider, one quotient bit per cycle, 30-bit operands.
// Uses vbmm_pkg.
`default_nettype none
module vbmm_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [vbmm_pkg::DIV_BITS-1:0] dividend,
  input  wire logic [vbmm_pkg::DIV_BITS-1:0] divisor,
  output logic                               done,
  output logic [vbmm_pkg::DIV_BITS-1:0]      quot,
  output logic [vbmm_pkg::DIV_BITS-1:0]      rem
);
  localparam int W = vbmm_pkg::DIV_BITS;
  logic [W-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [$clog2(W+1)-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0] trial;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {r_r, q_r[W-1]} - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend; r_nxt = '0; d_nxt = divisor;
      cnt_nxt = W[$clog2(W+1)-1:0]; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[W]) begin
        r_nxt = {r_r[W-2:0], q_r[W-1]};
        q_nxt = {q_r[W-2:0], 1'b0};
      end else begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  // a leftover pass may finish just as a new one is launched
  assign done = done_r & ~start;
  assign quot = q_r;
  assign rem  = r_r;
endmodule
`default_nettype wire

/* src/vbmm_datapath.sv */
// Datapath: config registers, operand registers, shared divider, brick tables.
// Uses vbmm_pkg and vbmm_div.
`default_nettype none
module vbmm_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [10:0]         cfg_data,
  input  wire vbmm_pkg::in_item_t  item,
  input  wire vbmm_pkg::cmd_t      cmd,
  output vbmm_pkg::sts_t           sts,
  output logic                     out_valid,
  output vbmm_pkg::out_item_t      out_item
);
  localparam int W  = vbmm_pkg::DIV_BITS;
  localparam int BB = vbmm_pkg::BRICK_BITS;

  logic [10:0] dx_r, dy_r, dz_r;
  logic [4:0]  bs_r;
  vbmm_pkg::in_item_t it_r;
  logic [W-1:0] a_r, b_r, x_r, yz_r, bx_r, by_r, bz_r, nx_r, ny_r;
  logic [33:0]  vol_r;
  logic [43:0]  bn_r;
  logic outside_r, valid_rd_r;
  logic signed [31:0] lo_rd_r, hi_rd_r, lo_w, hi_w;
  logic valid_mem [vbmm_pkg::MAX_BRICKS];
  logic [BB-1:0] clr_addr_r;
  logic clr_busy_r;
  logic signed [31:0] low_mem [vbmm_pkg::MAX_BRICKS];
  logic signed [31:0] high_mem [vbmm_pkg::MAX_BRICKS];
  logic out_valid_r;
  vbmm_pkg::out_item_t out_r;

  logic [10:0] dxe, dye, dze;
  logic [4:0]  bse;
  logic [W-1:0] dv_a, dv_b, q, rm;
  logic dv_done;
  logic [BB-1:0] addr;
  logic beyond;
  logic [23:0] byn_p, bzn_p;
  logic [35:0] bzny_p;

  assign dxe = (dx_r == 0) ? 11'd1 : dx_r;
  assign dye = (dy_r == 0) ? 11'd1 : dy_r;
  assign dze = (dz_r == 0) ? 11'd1 : dz_r;
  assign bse = (bs_r == 0) ? 5'd1 : bs_r;

  always_comb begin
    dv_a = a_r; dv_b = b_r;
  end

  vbmm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(dv_a), .divisor(dv_b), .done(dv_done), .quot(q), .rem(rm)
  );

  assign addr   = it_r.req_type ? it_r.read_brick[BB-1:0] : bn_r[BB-1:0];
  assign beyond = it_r.req_type ? 1'b0 : (bn_r >= 44'(vbmm_pkg::MAX_BRICKS));

  // brick number terms: by*nbx, bz*nbx, then (bz*nbx)*nby
  assign byn_p  = {12'd0, by_r[11:0]} * {12'd0, nx_r[11:0]};
  assign bzn_p  = {13'd0, bz_r[10:0]} * {12'd0, nx_r[11:0]};
  assign bzny_p = {13'd0, bz_r[22:0]} * {24'd0, ny_r[11:0]};

  // fold the sample into what was read
  always_comb begin
    if (!valid_rd_r) begin
      lo_w = it_r.sample_value; hi_w = it_r.sample_value;
    end else begin
      lo_w = (it_r.sample_value < lo_rd_r) ? it_r.sample_value : lo_rd_r;
      hi_w = (it_r.sample_value > hi_rd_r) ? it_r.sample_value : hi_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      vbmm_pkg::OP_LOAD: begin
        it_r <= item;
        vol_r <= 34'(22'(dxe) * 22'(dye));
      end
      vbmm_pkg::OP_VOLCHK: begin
        outside_r <= 45'(it_r.voxel_index) >= 45'(vol_r[21:0]) * 45'(dze);
        a_r <= it_r.voxel_index; b_r <= W'(dxe);
      end
      vbmm_pkg::OP_DIV_X: if (dv_done) begin
        x_r <= rm; a_r <= q; b_r <= W'(dye);
      end
      vbmm_pkg::OP_DIV_Y: if (dv_done) begin
        yz_r <= q; a_r <= x_r; x_r <= rm; b_r <= W'(bse);
      end
      vbmm_pkg::OP_DIV_BX: if (dv_done) begin
        bx_r <= q; a_r <= x_r; b_r <= W'(bse);
      end
      vbmm_pkg::OP_DIV_BY: if (dv_done) begin
        by_r <= q; a_r <= yz_r;
      end
      vbmm_pkg::OP_DIV_BZ: if (dv_done) begin
        bz_r <= q; a_r <= W'(dxe) + W'(bse) - 1'b1;
      end
      vbmm_pkg::OP_DIV_NX: if (dv_done) begin
        nx_r <= q; a_r <= W'(dye) + W'(bse) - 1'b1;
        bn_r <= 44'(bx_r);
      end
      vbmm_pkg::OP_DIV_NY: if (dv_done) begin
        ny_r <= q;
        bn_r <= bn_r + 44'(byn_p);
        bz_r <= W'(bzn_p);
      end
      vbmm_pkg::OP_SUM: bn_r <= bn_r + 44'(bzny_p);
      vbmm_pkg::OP_RD: begin
        lo_rd_r <= low_mem[addr];
        hi_rd_r <= high_mem[addr];
        valid_rd_r <= valid_mem[addr];
      end
      default: ;
    endcase
    if (cmd.op == vbmm_pkg::OP_WR && !it_r.req_type && !beyond) begin
      low_mem[addr]  <= lo_w;
      high_mem[addr] <= hi_w;
    end
    if (clr_busy_r)
      valid_mem[clr_addr_r] <= 1'b0;
    else if (cmd.op == vbmm_pkg::OP_WR && !it_r.req_type && !beyond)
      valid_mem[addr] <= 1'b1;
    out_r.brick_number <= it_r.req_type ? it_r.read_brick : bn_r[11:0];
    if (it_r.req_type) begin
      out_r.status <= vbmm_pkg::ST_OK; out_r.brick_seen <= valid_rd_r;
      out_r.brick_min <= valid_rd_r ? lo_rd_r : '0;
      out_r.brick_max <= valid_rd_r ? hi_rd_r : '0;
    end else if (outside_r) begin
      out_r <= '{vbmm_pkg::ST_OUTSIDE, 12'd0, 32'sd0, 32'sd0, 1'b0};
    end else if (beyond) begin
      out_r.status <= vbmm_pkg::ST_BEYOND; out_r.brick_seen <= 1'b0;
      out_r.brick_min <= '0; out_r.brick_max <= '0;
    end else begin
      out_r.status <= vbmm_pkg::ST_OK; out_r.brick_seen <= 1'b1;
      out_r.brick_min <= lo_w; out_r.brick_max <= hi_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx_r <= 11'd1; dy_r <= 11'd1; dz_r <= 11'd1; bs_r <= 5'd4;
      clr_busy_r <= 1'b1; clr_addr_r <= '0; out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          vbmm_pkg::REG_DIM_X: dx_r <= cfg_data;
          vbmm_pkg::REG_DIM_Y: dy_r <= cfg_data;
          vbmm_pkg::REG_DIM_Z: dz_r <= cfg_data;
          vbmm_pkg::REG_BRICK: bs_r <= cfg_data[4:0];
        endcase
      end
      // seen-flag clearing pass, one entry per cycle after reset
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == BB'(vbmm_pkg::MAX_BRICKS - 1)) clr_busy_r <= 1'b0;
      end
      out_valid_r <= (cmd.op == vbmm_pkg::OP_OUT);
    end
  end

  assign sts.div_done = dv_done;
  assign sts.is_read  = it_r.req_type;
  assign sts.outside  = outside_r;
  assign sts.clearing = clr_busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
endmodule
`default_nettype wire

/* src/vbmm_ctrl.sv */
// Controller FSM sequencing the datapath through each request.
// Uses vbmm_pkg.
`default_nettype none
module vbmm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire vbmm_pkg::sts_t sts,
  output vbmm_pkg::cmd_t      cmd
);
  vbmm_pkg::state_t st_r, st_nxt;
  logic kick_r, kick_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= vbmm_pkg::S_IDLE; kick_r <= 1'b0;
    end else begin
      st_r <= st_nxt; kick_r <= kick_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r; kick_nxt = 1'b0;
    cmd.op = vbmm_pkg::OP_NONE; cmd.div_start = kick_r;
    unique case (st_r)
      vbmm_pkg::S_IDLE: if (start && !sts.clearing) begin
        cmd.op = vbmm_pkg::OP_LOAD; st_nxt = vbmm_pkg::S_VOL;
      end
      vbmm_pkg::S_VOL: begin
        cmd.op = vbmm_pkg::OP_VOLCHK;
        if (sts.is_read) st_nxt = vbmm_pkg::S_RD;
        else begin st_nxt = vbmm_pkg::S_DX; kick_nxt = 1'b1; end
      end
      vbmm_pkg::S_DX: begin
        cmd.op = vbmm_pkg::OP_DIV_X;
        if (sts.outside) st_nxt = vbmm_pkg::S_OUT;
        else if (sts.div_done) begin st_nxt = vbmm_pkg::S_DY; kick_nxt = 1'b1; end
      end
      vbmm_pkg::S_DY: begin
        cmd.op = vbmm_pkg::OP_DIV_Y;
        if (sts.div_done) begin st_nxt = vbmm_pkg::S_BX; kick_nxt = 1'b1; end
      end
      vbmm_pkg::S_BX: begin
        cmd.op = vbmm_pkg::OP_DIV_BX;
        if (sts.div_done) begin st_nxt = vbmm_pkg::S_BY; kick_nxt = 1'b1; end
      end
      vbmm_pkg::S_BY: begin
        cmd.op = vbmm_pkg::OP_DIV_BY;
        if (sts.div_done) begin st_nxt = vbmm_pkg::S_BZ; kick_nxt = 1'b1; end
      end
      vbmm_pkg::S_BZ: begin
        cmd.op = vbmm_pkg::OP_DIV_BZ;
        if (sts.div_done) begin st_nxt = vbmm_pkg::S_NX; kick_nxt = 1'b1; end
      end
      vbmm_pkg::S_NX: begin
        cmd.op = vbmm_pkg::OP_DIV_NX;
        if (sts.div_done) begin st_nxt = vbmm_pkg::S_NY; kick_nxt = 1'b1; end
      end
      vbmm_pkg::S_NY: begin
        cmd.op = vbmm_pkg::OP_DIV_NY;
        if (sts.div_done) st_nxt = vbmm_pkg::S_SUM;
      end
      vbmm_pkg::S_SUM: begin cmd.op = vbmm_pkg::OP_SUM; st_nxt = vbmm_pkg::S_RD; end
      vbmm_pkg::S_RD:  begin cmd.op = vbmm_pkg::OP_RD;  st_nxt = vbmm_pkg::S_WR; end
      vbmm_pkg::S_WR:  begin cmd.op = vbmm_pkg::OP_WR;  st_nxt = vbmm_pkg::S_OUT; end
      vbmm_pkg::S_OUT: begin cmd.op = vbmm_pkg::OP_OUT; st_nxt = vbmm_pkg::S_IDLE; end
      default: st_nxt = vbmm_pkg::S_IDLE;
    endcase
  end

  assign busy = (st_r != vbmm_pkg::S_IDLE) || sts.clearing;
endmodule
`default_nettype wire

/* src/volume_block_min_max_core.sv */
// Top level of the brick min/max block: controller plus datapath.
// Uses vbmm_pkg, vbmm_ctrl, vbmm_datapath.
`default_nettype none
// Per-brick min/max of a 3D volume.
// Requests are taken on in_item when start is high and busy low. A sample
// request locates its brick through seven passes of one shared 30-step
// radix-2 divider (x, y, brick coordinates, bricks per axis), then reads,
// folds and writes the brick tables. Reads skip the divider, and a sample
// whose index lies outside the volume skips the brick lookup. One request at
// a time; busy falls in the cycle that presents the result, so the next
// request can be taken there.
// Each result appears on out_item for one cycle with out_valid high; the
// receiver has no way to stall it.
// cfg_we/cfg_index/cfg_data write dim_x, dim_y, dim_z, brick_size while
// busy is low. Reset (rst_n low, synchronous) loads the register defaults
// and starts a pass that clears the brick seen flags, one per cycle; busy
// stays high until all 4096 flags are clear. Table contents need no clearing.
module volume_block_min_max_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire vbmm_pkg::in_item_t  in_item,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [10:0]         cfg_data,
  output logic                     out_valid,
  output vbmm_pkg::out_item_t      out_item
);
  vbmm_pkg::cmd_t cmd;
  vbmm_pkg::sts_t sts;

  vbmm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  vbmm_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .item(in_item), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_item(out_item)
  );

  a_out_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without request");
  a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy after result");
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.status != 2'd3) else $error("bad status");
endmodule
`default_nettype wire

/* verif/tb_volume_block_min_max_core.sv */
// Testbench for volume_block_min_max_core: drives sample and read requests under
// several register settings and checks each result against a brick min/max predictor.
// Depends on vbmm_pkg and the RTL of the block.
`default_nettype none
module tb_volume_block_min_max_core;
  timeunit 1ns;
  timeprecision 1ps;
  import vbmm_pkg::*;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;
  localparam int   CYCLE_LIMIT = 4000000;
  localparam int   DRAIN_CYCLES = 300;

  class brick_scoreboard;
    logic        seen_flag [MAX_BRICKS];
    logic [31:0] low_val   [MAX_BRICKS];
    logic [31:0] high_val  [MAX_BRICKS];
    int          seen_list [$];
    out_item_t   expected_q [$];
    logic [10:0] dim_x, dim_y, dim_z;
    logic [4:0]  edge_len;
    int          mismatches;
    int          checked;

    function void clear();
      foreach (seen_flag[i]) seen_flag[i] = 1'b0;
      dim_x = 11'd1; dim_y = 11'd1; dim_z = 11'd1; edge_len = 5'd4;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [10:0] data);
      case (idx)
        REG_DIM_X: dim_x = data;
        REG_DIM_Y: dim_y = data;
        REG_DIM_Z: dim_z = data;
        REG_BRICK: edge_len = data[4:0];
        default: ;
      endcase
    endfunction

    function longint unsigned volume();
      longint unsigned dx, dy, dz;
      dx = (dim_x == 0) ? 1 : dim_x;
      dy = (dim_y == 0) ? 1 : dim_y;
      dz = (dim_z == 0) ? 1 : dim_z;
      return dx * dy * dz;
    endfunction

    function void note_request(in_item_t it);
      out_item_t e;
      longint unsigned dx, dy, dz, bs, idx, x, y, z, nbx, nby, bnum;
      logic signed [31:0] v;
      e = '0;
      dx = (dim_x == 0) ? 1 : dim_x;
      dy = (dim_y == 0) ? 1 : dim_y;
      dz = (dim_z == 0) ? 1 : dim_z;
      bs = (edge_len == 0) ? 1 : edge_len;
      if (it.req_type == REQ_READ) begin
        e.brick_number = it.read_brick;
        e.status = ST_OK;
        if (seen_flag[it.read_brick]) begin
          e.brick_min = low_val[it.read_brick];
          e.brick_max = high_val[it.read_brick];
          e.brick_seen = 1'b1;
        end
      end else begin
        idx = it.voxel_index;
        v = it.sample_value;
        if (idx >= dx * dy * dz) begin
          e.status = ST_OUTSIDE;
        end else begin
          x = idx % dx;
          y = (idx / dx) % dy;
          z = idx / dx / dy;
          nbx = (dx + bs - 1) / bs;
          nby = (dy + bs - 1) / bs;
          bnum = x / bs + (y / bs) * nbx + (z / bs) * nbx * nby;
          e.brick_number = bnum[11:0];
          if (bnum >= MAX_BRICKS) begin
            e.status = ST_BEYOND;
          end else begin
            if (!seen_flag[bnum]) begin
              seen_flag[bnum] = 1'b1;
              seen_list.push_back(int'(bnum));
              low_val[bnum] = v;
              high_val[bnum] = v;
            end else begin
              if (v < $signed(low_val[bnum])) low_val[bnum] = v;
              if (v > $signed(high_val[bnum])) high_val[bnum] = v;
            end
            e.status = ST_OK;
            e.brick_min = low_val[bnum];
            e.brick_max = high_val[bnum];
            e.brick_seen = 1'b1;
          end
        end
      end
      expected_q.push_back(e);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result st=%0d bn=%0d", got.status, got.brick_number);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.status !== e.status || got.brick_number !== e.brick_number ||
          got.brick_min !== e.brick_min || got.brick_max !== e.brick_max ||
          got.brick_seen !== e.brick_seen) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: exp st=%0d bn=%0d min=%0d max=%0d seen=%0d, got st=%0d bn=%0d min=%0d max=%0d seen=%0d",
                   e.status, e.brick_number, e.brick_min, e.brick_max, e.brick_seen,
                   got.status, got.brick_number, got.brick_min, got.brick_max,
                   got.brick_seen);
      end
    endfunction
  endclass

  logic        clk, rst_n, start, busy, cfg_we, out_valid;
  in_item_t    in_item;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;
  out_item_t   out_item;

  brick_scoreboard sb;
  longint unsigned cycles;
  int burst_left;
  int n_samples, n_reads;

  volume_block_min_max_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // one request: held until taken, start left high for a possible follow-on
  task automatic send_request(in_item_t it);
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_request(it);
    if (it.req_type == REQ_READ) n_reads++; else n_samples++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_q.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic set_volume(logic [10:0] x, logic [10:0] y, logic [10:0] z, logic [10:0] b);
    wait_idle();
    write_reg(REG_DIM_X, x);
    write_reg(REG_DIM_Y, y);
    write_reg(REG_DIM_Z, z);
    write_reg(REG_BRICK, b);
  endtask

  function automatic in_item_t sample_req(logic [29:0] idx, logic [31:0] v);
    in_item_t it;
    it = '0;
    it.req_type = REQ_SAMPLE;
    it.voxel_index = idx;
    it.sample_value = v;
    it.read_brick = 12'($urandom);
    return it;
  endfunction

  function automatic in_item_t read_req(logic [11:0] b);
    in_item_t it;
    it.req_type = REQ_READ;
    it.voxel_index = 30'($urandom);
    it.sample_value = $urandom;
    it.read_brick = b;
    return it;
  endfunction

  task automatic random_items(int n);
    in_item_t it;
    longint unsigned vol, span;
    logic [31:0] v;
    int r;
    for (int i = 0; i < n; i++) begin
      vol = sb.volume();
      span = (vol > 64'h4000_0000) ? 64'h4000_0000 : vol;
      r = $urandom_range(0, 99);
      if (r < 25 && sb.seen_list.size() != 0) begin
        it = read_req(12'(sb.seen_list[$urandom_range(0, sb.seen_list.size() - 1)]));
      end else begin
        case ($urandom_range(0, 9))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          default: v = $urandom;
        endcase
        if (r < 31)
          it = sample_req(30'($urandom), v);
        else if (r < 36 && vol < 64'h4000_0000)
          it = sample_req(30'(vol + $urandom_range(0, 5)), v);
        else
          it = sample_req(30'({$urandom, $urandom} % span), v);
      end
      send_request(it);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = REG_DIM_X;
    cfg_data = '0;
    burst_left = 0;
    n_samples = 0;
    n_reads = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: a single voxel
    send_request(sample_req(30'd0, 32'h7FFF_FFFF));
    send_request(sample_req(30'd0, 32'h8000_0000));
    send_request(read_req(12'd0));
    send_request(sample_req(30'd1, 32'd5));
    send_request(sample_req(30'h3FFF_FFFF, 32'd5));
    random_items(60);

    // one point per brick, table exactly full
    set_volume(11'd16, 11'd16, 11'd16, 11'd1);
    send_request(sample_req(30'd4095, 32'd9));
    send_request(read_req(12'd4095));
    send_request(sample_req(30'd4096, 32'd9));
    send_request(sample_req(30'd17, 32'hFFFF_FFFF));
    send_request(sample_req(30'd17, 32'd3));
    send_request(read_req(12'd17));
    random_items(450);

    // largest stated settings, most bricks off the table
    set_volume(11'd1024, 11'd1024, 11'd1024, 11'd16);
    send_request(sample_req(30'h3FFF_FFFF, 32'd1));
    send_request(sample_req(30'd0, 32'd2));
    send_request(sample_req(30'd1023, 32'd3));
    random_items(250);

    // zero registers act as one
    set_volume(11'd0, 11'd0, 11'd0, 11'd0);
    send_request(sample_req(30'd0, 32'd42));
    send_request(sample_req(30'd1, 32'd42));
    random_items(60);

    // all data bits set, above the stated range
    set_volume(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF);
    send_request(sample_req(30'h3FFF_FFFF, 32'd7));
    send_request(sample_req(30'd2046, 32'd7));
    random_items(250);

    set_volume(11'd37, 11'd5, 11'd9, 11'd3);
    random_items(300);
    set_volume(11'd100, 11'd60, 11'd3, 11'd7);
    random_items(250);
    set_volume(11'd8, 11'd8, 11'd8, 11'd2);
    random_items(250);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d sample and %0d read requests over eight register settings,",
             n_samples, n_reads);
    $display("%0d results checked, %0d mismatches, %0d bricks seen.",
             sb.checked, sb.mismatches, sb.seen_list.size());
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
